>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the substring coverage block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is applied.
`define BSRC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define BSRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bsrc_pkg.sv
// Types and fixed constants of the binary substring range coverage block.
// No dependencies.
`timescale 1ns / 1ps

package bsrc_pkg;

  localparam int LIMIT_W = 12;
  localparam int K_W = 4;
  localparam int COUNT_W = 12;
  localparam int EPOCH_W = 6;
  localparam int OUT_TDATA_W = 16;
  localparam int IN_TDATA_W = 8;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;

  typedef struct packed {
    logic x_vld;
    logic y_vld;
    logic last;
  } probe_t;

  typedef struct packed {
    logic [COUNT_W-1:0] distinct_found;
    logic               all_covered;
  } result_t;

endpackage

>>> hw/rtl/binary_substring_range_coverage.sv
// Top level: coverage check of 1..n as substrings of a streamed binary string.
// Depends on bsrc_pkg, bsrc_window, bsrc_seen_mem, bsrc_result_fifo, assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | tdata[0] bit_value, tlast last_bit
//  out_    | master    | out_tvalid/tready  | tdata[0] all_covered, [12:1] distinct_found
//  cfg_    | write     | cfg_wr_en          | cfg_wr_data limit_n
//
// Each input bit makes up to two tag reads of the seen memory (one per window
// width), one read port, one read per cycle; input is not ready while the first is issued.
// A result passes the issue and return stages before it enters the queue.
// After reset the tag memory is cleared by a sweep of every entry; the same sweep
// runs again after every 63 strings, once the pipeline has drained.
// Input stalls while two results wait or are in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_substring_range_coverage #(
  parameter int MAX_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bsrc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [0] bit_value
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bsrc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [0] all_covered, [12:1] distinct_found
  input  logic                              cfg_wr_en,
  input  logic [bsrc_pkg::LIMIT_W-1:0]      cfg_wr_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam int EW = bsrc_pkg::EPOCH_W;
  localparam int CNT_W = bsrc_pkg::COUNT_W;

  logic [bsrc_pkg::LIMIT_W-1:0] limit_r;
  logic [bsrc_pkg::LIMIT_W-1:0] eff_n;
  logic [1:0]                   state_r;
  logic [MAX_BITS-1:0]          sweep_addr_r;
  logic [EW-1:0]                epoch_r;
  logic [1:0]                   pend_r;
  logic                         accept;
  logic                         res_pop;

  logic [MAX_BITS-1:0]          win_x;
  logic [MAX_BITS-1:0]          win_y;
  bsrc_pkg::probe_t             win_probe;

  logic                         iss_vld_r;
  logic                         iss_ph_r;
  logic [MAX_BITS-1:0]          iss_x_r;
  logic [MAX_BITS-1:0]          iss_y_r;
  bsrc_pkg::probe_t             iss_probe_r;
  logic [EW-1:0]                iss_epoch_r;

  logic                         ret_vld_r;
  logic                         ret_chk_r;
  logic                         ret_last_r;
  logic [MAX_BITS-1:0]          ret_addr_r;
  logic [EW-1:0]                ret_epoch_r;

  logic                         rd_en;
  logic                         rd_chk;
  logic [MAX_BITS-1:0]          rd_addr;
  logic [EW-1:0]                rd_data;
  logic                         mem_we;
  logic [MAX_BITS-1:0]          mem_waddr;
  logic [EW-1:0]                mem_wdata;
  logic                         sweeping;
  logic                         hit;

  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_inc;
  logic [CNT_W-1:0]             required;
  bsrc_pkg::result_t            res_data;
  bsrc_pkg::result_t            res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= bsrc_pkg::LIMIT_W'(1);
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  assign in_tready = (state_r == ST_RUN) && (!iss_vld_r || iss_ph_r) && (pend_r < 2'd2);
  assign accept = in_tvalid && in_tready;

  bsrc_window #(
    .MAX_BITS(MAX_BITS)
  ) u_window (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .bit_value(in_tdata[0]),
    .last_bit(in_tlast),
    .limit_n(limit_r),
    .x_addr(win_x),
    .y_addr(win_y),
    .probe(win_probe),
    .eff_n(eff_n)
  );

  // issue stage: read x tag in phase 0, y tag in phase 1
  always_ff @(posedge clk) begin
    if (accept) begin
      iss_x_r <= win_x;
      iss_y_r <= win_y;
      iss_probe_r <= win_probe;
      iss_epoch_r <= epoch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_vld_r <= 1'b0;
      iss_ph_r <= 1'b0;
    end else if (accept) begin
      iss_vld_r <= 1'b1;
      iss_ph_r <= 1'b0;
    end else if (iss_vld_r && !iss_ph_r) begin
      iss_ph_r <= 1'b1;
    end else begin
      iss_vld_r <= 1'b0;
    end
  end

  assign rd_chk = iss_ph_r ? iss_probe_r.y_vld : iss_probe_r.x_vld;
  assign rd_addr = iss_ph_r ? iss_y_r : iss_x_r;
  assign rd_en = iss_vld_r && rd_chk;

  // return stage: test tag against the string's epoch, set on a miss
  always_ff @(posedge clk) begin
    if (iss_vld_r) begin
      ret_addr_r <= rd_addr;
      ret_epoch_r <= iss_epoch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_vld_r <= 1'b0;
      ret_chk_r <= 1'b0;
      ret_last_r <= 1'b0;
    end else begin
      ret_vld_r <= iss_vld_r;
      ret_chk_r <= iss_vld_r && rd_chk;
      ret_last_r <= iss_vld_r && iss_ph_r && iss_probe_r.last;
    end
  end

  assign hit = ret_vld_r && ret_chk_r && (rd_data != ret_epoch_r);
  assign sweeping = (state_r == ST_CLEAR);
  assign mem_we = sweeping || hit;
  assign mem_waddr = sweeping ? sweep_addr_r : ret_addr_r;
  assign mem_wdata = sweeping ? bsrc_pkg::EPOCH_CLEAR : ret_epoch_r;

  bsrc_seen_mem #(
    .ADDR_W(MAX_BITS),
    .DATA_W(EW)
  ) u_seen_mem (
    .clk(clk),
    .wr_en(mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign count_inc = count_r + CNT_W'(hit);
  assign required = CNT_W'(eff_n - (eff_n >> 1));
  assign res_data.all_covered = (count_inc == required);
  assign res_data.distinct_found = count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ret_vld_r && ret_last_r) begin
      count_r <= '0;
    end else begin
      count_r <= count_inc;
    end
  end

  // sweep control and string epochs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sweep_addr_r <= '0;
      epoch_r <= bsrc_pkg::EPOCH_FIRST;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          sweep_addr_r <= sweep_addr_r + MAX_BITS'(1);
          if (sweep_addr_r == {MAX_BITS{1'b1}}) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (accept && in_tlast) begin
            if (epoch_r == bsrc_pkg::EPOCH_MAX) begin
              epoch_r <= bsrc_pkg::EPOCH_FIRST;
              state_r <= ST_DRAIN;
            end else begin
              epoch_r <= epoch_r + EW'(1);
            end
          end
        end
        ST_DRAIN: begin
          if (!iss_vld_r && !ret_vld_r) begin
            sweep_addr_r <= '0;
            state_r <= ST_CLEAR;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
          sweep_addr_r <= '0;
        end
      endcase
    end
  end

  bsrc_result_fifo u_result_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(ret_vld_r && ret_last_r),
    .push_data(res_data),
    .pop_vld(out_tvalid),
    .pop_rdy(out_tready),
    .pop_data(res_out)
  );

  assign res_pop = out_tvalid && out_tready;
  assign out_tdata = {{(bsrc_pkg::OUT_TDATA_W - CNT_W - 1){1'b0}}, res_out};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, accept && in_tlast} - {1'b0, res_pop};
    end
  end

  `BSRC_ASSERT_RST(a_no_rw_same_entry, clk, rst_n, (hit && rd_en) |-> (ret_addr_r != rd_addr), "tag read and write hit the same entry")
  `BSRC_ASSERT_RST(a_no_accept_off_run, clk, rst_n, (state_r != ST_RUN) |-> !in_tready, "input taken during sweep or drain")
  `BSRC_ASSERT_RST(a_issue_after_accept, clk, rst_n, accept |=> (iss_vld_r && !iss_ph_r), "accepted bit did not enter issue stage")
  `BSRC_ASSERT_RST(a_sweep_idle_pipe, clk, rst_n, sweeping |-> (!ret_vld_r && !iss_vld_r), "sweep overlaps tag accesses")
  `BSRC_ASSERT_ALWAYS(a_pend_bound, clk, !rst_n || (pend_r != 2'd3), "results pending beyond queue depth")

endmodule

>>> hw/rtl/bsrc_window.sv
// Bit window, fill count and range checks of both window widths.
// Depends on bsrc_pkg.
`timescale 1ns / 1ps

module bsrc_window #(
  parameter int MAX_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          bit_value,
  input  logic                          last_bit,
  input  logic [bsrc_pkg::LIMIT_W-1:0]  limit_n,
  output logic [MAX_BITS-1:0]           x_addr,
  output logic [MAX_BITS-1:0]           y_addr,
  output bsrc_pkg::probe_t              probe,
  output logic [bsrc_pkg::LIMIT_W-1:0]  eff_n
);

  localparam int CW = (MAX_BITS > bsrc_pkg::LIMIT_W) ? MAX_BITS : bsrc_pkg::LIMIT_W;
  localparam int TK_W = $clog2(MAX_BITS + 1);
  localparam logic [CW-1:0] WIN_MAX = CW'((64'd1 << MAX_BITS) - 64'd1);
  localparam logic [TK_W-1:0] TAKEN_MAX = TK_W'(MAX_BITS);

  logic [MAX_BITS-1:0]        window_r;
  logic [MAX_BITS-1:0]        window_nxt;
  logic [TK_W-1:0]            taken_r;
  logic [TK_W-1:0]            taken_nxt;
  logic [MAX_BITS:0]          win_ext;
  logic [CW-1:0]              lim_c;
  logic [CW-1:0]              eff_c;
  logic [CW-1:0]              half_c;
  logic [CW-1:0]              x_c;
  logic [CW-1:0]              y_c;
  logic [bsrc_pkg::K_W-1:0]   k;
  logic [MAX_BITS-1:0]        kmask;
  logic [MAX_BITS-1:0]        k1mask;
  logic [MAX_BITS-1:0]        topmask;
  logic                       top_set;

  always_comb begin
    lim_c = CW'(limit_n);
    eff_c = (lim_c > WIN_MAX) ? WIN_MAX : lim_c;
    eff_n = eff_c[bsrc_pkg::LIMIT_W-1:0];
    k = '0;
    for (int i = 0; i < bsrc_pkg::LIMIT_W; i++) begin
      if (eff_n[i]) begin
        k = bsrc_pkg::K_W'(i + 1);
      end
    end
  end

  always_comb begin
    win_ext = {window_r, bit_value};
    window_nxt = win_ext[MAX_BITS-1:0];
    taken_nxt = (taken_r < TAKEN_MAX) ? taken_r + TK_W'(1) : taken_r;
    for (int i = 0; i < MAX_BITS; i++) begin
      kmask[i] = (i < int'(k));
      k1mask[i] = ((i + 1) < int'(k));
      topmask[i] = ((i + 1) == int'(k));
    end
    x_addr = window_nxt & kmask;
    y_addr = window_nxt & k1mask;
    top_set = |(window_nxt & topmask);
    x_c = CW'(x_addr);
    y_c = CW'(y_addr);
    half_c = CW'(eff_n >> 1) + CW'(1);
    probe.x_vld = (k != '0) && (int'(taken_nxt) >= int'(k)) && top_set && (x_c <= eff_c);
    probe.y_vld = (int'(k) >= 2) && (int'(taken_nxt) >= (int'(k) - 1)) && (y_c >= half_c);
    probe.last = last_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      taken_r <= '0;
    end else if (accept) begin
      if (last_bit) begin
        window_r <= '0;
        taken_r <= '0;
      end else begin
        window_r <= window_nxt;
        taken_r <= taken_nxt;
      end
    end
  end

endmodule

>>> hw/rtl/bsrc_seen_mem.sv
// Seen-value tag memory: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module bsrc_seen_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/bsrc_result_fifo.sv
// Two-entry result queue in front of the output channel.
// Depends on bsrc_pkg.
`timescale 1ns / 1ps

module bsrc_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bsrc_pkg::result_t   push_data,
  output logic                pop_vld,
  input  logic                pop_rdy,
  output bsrc_pkg::result_t   pop_data
);

  bsrc_pkg::result_t ent_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              pop;

  assign pop_vld = (cnt_r != 2'd0);
  assign pop = pop_vld && pop_rdy;
  assign pop_data = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> dv/tb_binary_substring_range_coverage.sv
`timescale 1ns / 1ps
// Testbench for binary_substring_range_coverage: streams binary strings, predicts the
// coverage verdict per string and checks every result. Depends on bsrc_pkg and the RTL.

module tb_binary_substring_range_coverage;
  import bsrc_pkg::*;

  localparam int WIN_BITS = 12;
  localparam int MAP_SIZE = 1 << WIN_BITS;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 12;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;  // [0] bit_value
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [0] all_covered, [12:1] distinct_found
  logic                   cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]     cfg_wr_data = '0;

  always #5 clk = ~clk;

  binary_substring_range_coverage #(
    .MAX_BITS(WIN_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state
  logic [LIMIT_W-1:0]  limit_q = LIMIT_W'(1);
  logic [WIN_BITS-1:0] tail_bits;
  int                  tail_len;
  bit                  found_map [0:MAP_SIZE-1];
  int                  found_count;
  result_t             expected_verdicts[$];

  bit pattern_bits[$];
  bit in_idle_on;
  bit out_stall_on;
  int errors = 0;
  int items_sent = 0;
  int strings_sent = 0;
  int full_covers = 0;
  int limit_writes = 0;
  int idle_cycles = 0;

  function automatic void clear_string();
    tail_bits = '0;
    tail_len = 0;
    found_count = 0;
    found_map = '{default: 1'b0};
  endfunction

  function automatic void mark_found(int v);
    if (!found_map[v]) begin
      found_map[v] = 1'b1;
      found_count++;
    end
  endfunction

  function automatic void update_coverage(bit b, bit last);
    int n;
    int k;
    int x;
    int y;
    int top;
    result_t r;
    n = int'(limit_q);
    k = 0;
    while (k < WIN_BITS && (n >> k) != 0) k++;
    tail_bits = {tail_bits[WIN_BITS-2:0], b};
    if (tail_len < WIN_BITS) tail_len++;
    if (k >= 1 && tail_len >= k) begin
      x = int'(tail_bits) & ((1 << k) - 1);
      if (x >= (1 << (k - 1)) && x <= n) mark_found(x);
    end
    if (k >= 2 && tail_len >= k - 1) begin
      top = 1 << (k - 1);
      y = int'(tail_bits) & (top - 1);
      if (y >= n / 2 + 1 && y <= top - 1) mark_found(y);
    end
    if (last) begin
      r.all_covered = (found_count == n - n / 2);
      r.distinct_found = COUNT_W'(found_count);
      if (r.all_covered) full_covers++;
      expected_verdicts.push_back(r);
      clear_string();
    end
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_verdict(logic [OUT_TDATA_W-1:0] d);
    result_t e;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected result tdata=%h", d));
    end else begin
      e = expected_verdicts.pop_front();
      if (d[0] !== e.all_covered)
        report_mismatch($sformatf("all_covered got %b exp %b", d[0], e.all_covered));
      if (d[COUNT_W:1] !== e.distinct_found)
        report_mismatch($sformatf("distinct_found got %0d exp %0d",
                                  d[COUNT_W:1], e.distinct_found));
    end
  endtask

  task automatic send_bit(bit b, bit last);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = IN_TDATA_W'(b);
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    update_coverage(b, last);
    items_sent++;
  endtask

  // Hold input idle until every verdict is back and the pipeline is empty.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    settle();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = LIMIT_W'(v);
    @(posedge clk);
    limit_q = LIMIT_W'(v);
    limit_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic send_pattern(bit close);
    foreach (pattern_bits[i])
      send_bit(pattern_bits[i], close && i == pattern_bits.size() - 1);
    if (close) strings_sent++;
    pattern_bits.delete();
  endtask

  function automatic void load_bits(logic [31:0] v, int len);
    for (int i = len - 1; i >= 0; i--) pattern_bits.push_back(v[i]);
  endfunction

  function automatic void append_value(int v);
    int w;
    w = 0;
    while ((v >> w) != 0) w++;
    load_bits(v, w);
  endfunction

  function automatic void load_random(int len);
    repeat (len) pattern_bits.push_back(bit'($urandom_range(0, 1)));
  endfunction

  // Every value up to n/2 is a prefix of its double, so n/2+1..n covers the range.
  function automatic void load_covering(int n);
    load_random($urandom_range(0, 3));
    for (int v = n / 2 + 1; v <= n; v++) append_value(v);
  endfunction

  function automatic void damage_pattern();
    int idx;
    int keep;
    idx = $urandom_range(0, pattern_bits.size() - 1);
    case ($urandom_range(0, 5))
      0: pattern_bits[idx] = ~pattern_bits[idx];
      1: if (pattern_bits.size() > 1) pattern_bits.delete(idx);
      2: begin
        keep = idx + 1;
        while (pattern_bits.size() > keep) void'(pattern_bits.pop_back());
      end
      default: ;
    endcase
  endfunction

  task automatic test_directed();
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    write_limit(1);
    load_bits('b1, 1);
    send_pattern(1'b1);
    load_bits('b0, 1);
    send_pattern(1'b1);
    write_limit(0);
    load_bits('b1, 1);
    send_pattern(1'b1);
    write_limit(3);
    load_bits('b110, 3);
    send_pattern(1'b1);
    write_limit(4095);
    load_bits(32'hFFF, 12);
    send_pattern(1'b1);
    // change the limit in the middle of a string
    write_limit(2);
    load_bits('b1, 1);
    send_pattern(1'b0);
    write_limit(5);
    load_bits('b01, 2);
    send_pattern(1'b1);
    write_limit(2);
    load_bits('b10, 2);
    send_pattern(1'b1);
  endtask

  task automatic test_covering(int budget);
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < budget) begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(25, 63);
      write_limit(n);
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_stall_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        load_covering(n);
        damage_pattern();
        send_pattern(1'b1);
      end
    end
  endtask

  task automatic test_noise(int budget);
    int start;
    int n;
    start = items_sent;
    in_idle_on = 1'b1;
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 5))
        0: n = 0;
        1: n = 1;
        2: n = 4095;
        default: n = $urandom_range(1, 300);
      endcase
      write_limit(n);
      out_stall_on = ($urandom_range(0, 1) != 0);
      repeat ($urandom_range(1, 4)) begin
        load_random($urandom_range(1, 40));
        send_pattern(1'b1);
      end
    end
  endtask

  task automatic test_large_limit(int budget);
    int start;
    int n;
    start = items_sent;
    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 3))
        0: n = 2048;
        1: n = 2047;
        2: n = 4095;
        default: n = $urandom_range(1024, 4095);
      endcase
      write_limit(n);
      load_random($urandom_range(40, 120));
      send_pattern(1'b1);
    end
  endtask

  task automatic test_back_to_back(int budget);
    int start;
    int n;
    start = items_sent;
    in_idle_on = 1'b0;
    out_stall_on = 1'b0;
    while (items_sent - start < budget) begin
      n = $urandom_range(1, 16);
      write_limit(n);
      repeat ($urandom_range(2, 4)) begin
        load_covering(n);
        if ($urandom_range(0, 1) != 0) damage_pattern();
        send_pattern(1'b1);
      end
    end
  endtask

  initial begin : result_monitor
    int stall;
    forever begin
      stall = out_stall_on ? $urandom_range(0, 3) : 0;
      repeat (stall) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_verdict(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_string();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_covering(900);
    test_noise(350);
    test_large_limit(250);
    test_back_to_back(100);
    settle();
    $display("Summary: %0d bits in %0d strings, %0d limit writes, %0d strings fully covered",
             items_sent, strings_sent, limit_writes, full_covers);
    $display("Summary: limits from 0 to 4095, mid-string limit change, random idle and stall");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
